// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define TMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tmf_pkg.sv =====
// Shared types and constants for the touch ADC trimmed mean filter.
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int SAMPLES_PER_GROUP_DEF = 5;
    localparam int TRIM_EACH_END_DEF     = 1;

    localparam int SAMPLE_W  = 12;
    localparam int CHANNEL_W = 8;
    localparam int ERR_W     = 13;

    localparam logic [ERR_W-1:0] ERROR_RANGE_RESET = 13'd50;

    typedef struct packed {
        logic                insert;
        logic                shift;
        logic [SAMPLE_W-1:0] sample;
    } cell_ctrl_t;

endpackage

// ===== hdl/tmf_cell.sv =====
// One sorting cell: insertion-sort slot that can also shift toward cell 0.
`timescale 1ns / 1ps

module tmf_cell
    import tmf_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 3
)
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]    fill,
    input  logic [SAMPLE_W-1:0] left_value,
    input  logic                left_gt,
    input  logic [SAMPLE_W-1:0] right_value,
    output logic [SAMPLE_W-1:0] value,
    output logic                gt
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                occupied;

    assign occupied = (int'(fill) > IDX);
    assign gt       = occupied && (value_reg > ctrl.sample);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && (gt || !occupied))
        begin
            value_next = left_gt ? left_value : ctrl.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/tmf_div.sv =====
// Divider by a constant: latch the dividend, then multiply by its rounded-up reciprocal.
`timescale 1ns / 1ps

module tmf_div
#(
    parameter int SUM_W   = 15,
    parameter int DIVISOR = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    // exact floor division for every dividend below 2**SUM_W
    localparam int     SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int     MW      = SHIFT + 1;
    localparam int     PROD_W  = SUM_W + MW;
    localparam longint RECIP_L = ((longint'(1) <<< SHIFT) + longint'(DIVISOR) - longint'(1))
                                 / longint'(DIVISOR);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic              busy_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  dividend_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [PROD_W-1:0] product;

    assign product  = PROD_W'(dividend_reg) * PROD_W'(RECIP);
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
        end
        if (busy_reg)
        begin
            quo_reg <= product[SHIFT +: SUM_W];
        end
    end

endmodule

// ===== hdl/touch_adc_trimmed_mean_filter.sv =====
// Top level of the touch ADC trimmed mean filter.
//
//  port group   dir  fields (low bit up)                     beat accepted when
//  s_axis_*     in   tdata: sample[11:0]; tuser: channel      tvalid & tready
//  m_axis_*     out  tdata: value[11:0]; tuser: agreed,       tvalid & tready
//                    channel_out[7:0]
//  cfg_wr_*     in   error_range[12:0]                        cfg_wr_en
//
// A sample beat is insertion-sorted into the cell row as it is accepted.
// After a group's last beat come the drain through the row, the divide
// (latch sum, reciprocal multiply) and a finish step, with tready low
// meanwhile. The finish step of a pair waits while the output register
// still holds an unaccepted beat.
// Reset clears the counters, pair state, error_range (to 50) and output valid.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module touch_adc_trimmed_mean_filter
    import tmf_pkg::*;
#(
    parameter int SAMPLES_PER_GROUP = SAMPLES_PER_GROUP_DEF,
    parameter int TRIM_EACH_END     = TRIM_EACH_END_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // sample[11:0], zero pad
    input  logic [7:0]       s_axis_tuser,   // channel[7:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // value[11:0], zero pad
    output logic [8:0]       m_axis_tuser,   // agreed, channel_out[7:0]
    input  logic             cfg_wr_en,
    input  logic [ERR_W-1:0] cfg_wr_data     // error_range[12:0]
);

    localparam int N     = SAMPLES_PER_GROUP;
    localparam int CNT_W = $clog2(N + 1);
    localparam int LO    = TRIM_EACH_END;
    localparam int HI    = N - TRIM_EACH_END;
    localparam int KEEP  = (N > 2 * TRIM_EACH_END) ? (N - 2 * TRIM_EACH_END) : 0;
    localparam int DIV_K = (KEEP > 0) ? KEEP : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(N);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_DRAIN   = 2'd1;
    localparam logic [1:0] ST_DIV     = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0]           state_reg,     state_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic                 second_reg,    second_next;
    logic [SAMPLE_W-1:0]  first_avg_reg, first_avg_next;
    logic [CHANNEL_W-1:0] held_ch_reg,   held_ch_next;
    logic [SUM_W-1:0]     sum_reg,       sum_next;
    logic [SAMPLE_W-1:0]  avg_reg,       avg_next;
    logic [ERR_W-1:0]     err_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_value_reg, out_value_next;
    logic                 out_agreed_reg, out_agreed_next;
    logic [CHANNEL_W-1:0] out_ch_reg,    out_ch_next;

    logic                 in_acc;
    logic                 out_take;
    logic                 drain_last;
    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quo;
    logic [SAMPLE_W-1:0]  diff;
    logic [SAMPLE_W:0]    pair_sum;
    logic                 agree;
    cell_ctrl_t           cell_ctrl;

    logic [SAMPLE_W-1:0]  cell_value [N];
    logic                 cell_gt    [N];

    assign s_axis_tready = (state_reg == ST_COLLECT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign drain_last    = (state_reg == ST_DRAIN) && (cnt_reg == CNT_W'(N - 1));
    assign div_start     = drain_last;

    assign cell_ctrl.insert = in_acc;
    assign cell_ctrl.shift  = (state_reg == ST_DRAIN);
    assign cell_ctrl.sample = s_axis_tdata[SAMPLE_W-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic [SAMPLE_W-1:0] lv;
            logic                lg;
            logic [SAMPLE_W-1:0] rv;
            if (gi == 0)
            begin : g_head
                assign lv = '0;
                assign lg = 1'b0;
            end
            else
            begin : g_body
                assign lv = cell_value[gi-1];
                assign lg = cell_gt[gi-1];
            end
            if (gi == N - 1)
            begin : g_tail
                assign rv = '0;
            end
            else
            begin : g_mid
                assign rv = cell_value[gi+1];
            end
            tmf_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl),
                .fill        (cnt_reg),
                .left_value  (lv),
                .left_gt     (lg),
                .right_value (rv),
                .value       (cell_value[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    tmf_div #(
        .SUM_W   (SUM_W),
        .DIVISOR (DIV_K)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign diff     = (avg_reg > first_avg_reg) ? (avg_reg - first_avg_reg)
                                                : (first_avg_reg - avg_reg);
    assign agree    = ({1'b0, diff} < err_reg);
    assign pair_sum = {1'b0, avg_reg} + {1'b0, first_avg_reg};

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        second_next     = second_reg;
        first_avg_next  = first_avg_reg;
        held_ch_next    = held_ch_reg;
        sum_next        = sum_reg;
        avg_next        = avg_reg;
        out_valid_next  = out_valid_reg && !out_take;
        out_value_next  = out_value_reg;
        out_agreed_next = out_agreed_reg;
        out_ch_next     = out_ch_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc)
                begin
                    if ((cnt_reg == '0) && !second_reg)
                    begin
                        held_ch_next = s_axis_tuser;
                    end
                    if (cnt_reg == CNT_W'(N - 1))
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if ((int'(cnt_reg) >= LO) && (int'(cnt_reg) < HI))
                begin
                    sum_next = sum_reg + SUM_W'(cell_value[0]);
                end
                if (drain_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = (KEEP == 0) ? '0 : div_quo[SAMPLE_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!second_reg)
                begin
                    first_avg_next = avg_reg;
                    second_next    = 1'b1;
                    state_next     = ST_COLLECT;
                end
                else if (!out_valid_reg || out_take)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = agree ? pair_sum[SAMPLE_W:1] : '0;
                    out_agreed_next = agree;
                    out_ch_next     = held_ch_reg;
                    second_next     = 1'b0;
                    state_next      = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            cnt_reg       <= '0;
            second_reg    <= 1'b0;
            first_avg_reg <= '0;
            held_ch_reg   <= '0;
            err_reg       <= ERROR_RANGE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            second_reg    <= second_next;
            first_avg_reg <= first_avg_next;
            held_ch_reg   <= held_ch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                err_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        avg_reg        <= avg_next;
        out_value_reg  <= out_value_next;
        out_agreed_reg <= out_agreed_next;
        out_ch_reg     <= out_ch_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - SAMPLE_W){1'b0}}, out_value_reg};
    assign m_axis_tuser  = {out_ch_reg, out_agreed_reg};

    `TMF_ASSERT(a_cnt_in_group, clk, rst_n, (cnt_reg < CNT_W'(N)), "sample count out of group")
    `TMF_ASSERT(a_disagree_zero, clk, rst_n, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0), "value nonzero without agreement")
    `TMF_ASSERT(a_result_from_pair, clk, rst_n, $rose(m_axis_tvalid) |-> $past(second_reg), "result without second group")
    `TMF_ASSERT(a_div_only_in_div, clk, rst_n, div_done |-> (state_reg == ST_DIV), "divider finished outside divide state")

endmodule
